### rtl/tmpc_pkg.sv
`timescale 1ns / 1ps

package tmpc_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 16;
  localparam int CNT_W     = 4;
  localparam int CODE_W    = 14;
  localparam int MAG_W     = 13;
  localparam int MEAN_W    = 15;
  localparam int NUM_W     = SUM_W + 3;
  localparam int REM_W     = 4;
  localparam int COEF_W    = 48;
  localparam int ACC_W     = 64;
  localparam int BITCNT_W  = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBIC_COEFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_COEFF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_COEFF = 2'd3;

  localparam logic [SAMPLE_W-1:0]      ZERO_OFFSET_RST  = 12'd790;
  localparam logic signed [COEF_W-1:0] CUBIC_COEFF_RST  = -48'sd109951;
  localparam logic signed [COEF_W-1:0] SQUARE_COEFF_RST = 48'sd439804651;
  localparam logic signed [COEF_W-1:0] LINEAR_COEFF_RST = -48'sd253657332528;

  localparam logic [MAG_W-1:0] MAG_MAX = 13'h1fff;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      zero_offset;
    logic signed [COEF_W-1:0] cubic;
    logic signed [COEF_W-1:0] square;
    logic signed [COEF_W-1:0] linear;
  } tmpc_coef_t;

  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } tmpc_alu_req_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              updated;
    logic [MEAN_W-1:0] mean;
  } tmpc_result_t;

endpackage

### rtl/tmpc_if.sv
`timescale 1ns / 1ps

interface tmpc_in_if;
  import tmpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface tmpc_out_if;
  import tmpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] pressure_code;
  logic              updated;
  logic [MEAN_W-1:0] mean_level;
  modport source (output valid, output pressure_code, output updated, output mean_level,
                  input ready);
  modport sink (input valid, input pressure_code, input updated, input mean_level,
                output ready);
endinterface

### rtl/tmpc_alu.sv
`timescale 1ns / 1ps

module tmpc_alu
  import tmpc_pkg::*;
(
  input  tmpc_alu_req_t    req,
  output logic [ACC_W-1:0] sum
);

  // Subtraction is done as a + ~b + 1.
  assign sum = req.a + (req.sub ? ~req.b : req.b) + {{(ACC_W-1){1'b0}}, req.sub};

endmodule

### rtl/tmpc_core.sv
`timescale 1ns / 1ps

module tmpc_core
  import tmpc_pkg::*;
#(
  parameter int GROUP_SIZE = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [SUM_W-1:0] trimmed_i,
  input  tmpc_coef_t       coef_i,
  input  logic             take_i,
  output logic             idle_o,
  output tmpc_result_t     res_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_BIAS = 3'd4;
  localparam logic [2:0] ST_ADDC = 3'd5;
  localparam logic [2:0] ST_CODE = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  localparam logic [1:0] PH_A1 = 2'd0;
  localparam logic [1:0] PH_A2 = 2'd1;
  localparam logic [1:0] PH_P  = 2'd2;

  // The divide by GROUP_SIZE-2 is a multiply by its rounded-up reciprocal. With four
  // more fraction bits than the numerator has, the quotient is exact for every numerator.
  localparam int                DIV_SHIFT = NUM_W + 4;
  localparam int                RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP    =
    RECIP_W'(((1 << DIV_SHIFT) + GROUP_SIZE - 3) / (GROUP_SIZE - 2));
  localparam logic [ACC_W-1:0]  BIAS_Q3   = ACC_W'(7);
  localparam logic [ACC_W-1:0]  BIAS_Q43  = (ACC_W'(1) << 43) - ACC_W'(1);
  localparam int                P_W       = ACC_W - 43;

  logic [2:0]          state_r, state_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [BITCNT_W-1:0] cnt_r, cnt_nxt;
  logic [MEAN_W-1:0]   mean_r, mean_nxt;
  logic [ACC_W-1:0]    mcand_r, mcand_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [1:0]          ph_r, ph_nxt;
  logic [CODE_W-1:0]   held_r, held_nxt;
  logic                upd_r, upd_nxt;

  tmpc_alu_req_t       alu_req;
  logic [ACC_W-1:0]    alu_sum;
  logic [MEAN_W-1:0]   off8;
  logic [MEAN_W-1:0]   quo;
  logic [ACC_W-1:0]    sat_val;
  logic                sat_ovf;
  logic [P_W-1:0]      p_val;
  logic [P_W-1:0]      p_abs;
  logic [MAG_W-1:0]    mag;
  logic                below;

  tmpc_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  assign off8   = {coef_i.zero_offset, 3'b000};
  assign quo    = acc_r[DIV_SHIFT +: MEAN_W];
  assign below  = mean_r < off8;

  // Clamp the Horner sum to 48 signed bits, kept sign extended in the 64-bit word.
  assign sat_ovf = !((&alu_sum[ACC_W-1:COEF_W-1]) || !(|alu_sum[ACC_W-1:COEF_W-1]));
  always_comb begin
    if (!sat_ovf) begin
      sat_val = alu_sum;
    end else if (alu_sum[ACC_W-1]) begin
      sat_val = {{(ACC_W-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}};
    end else begin
      sat_val = {{(ACC_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
    end
  end

  // The final accumulator already carries the toward-zero bias, so this is the quotient.
  assign p_val = acc_r[ACC_W-1:43];
  assign p_abs = p_val[P_W-1] ? (~p_val + P_W'(1)) : p_val;

  always_comb begin
    if (below) begin
      mag = (|p_abs[P_W-1:MAG_W]) ? MAG_MAX : p_abs[MAG_W-1:0];
    end else if (p_val[P_W-1]) begin
      mag = '0;
    end else begin
      mag = (|p_val[P_W-2:MAG_W]) ? MAG_MAX : p_val[MAG_W-1:0];
    end
  end

  always_comb begin
    alu_req = '0;
    case (state_r)
      ST_DIV: begin
        alu_req.a = acc_r << 1;
        alu_req.b = RECIP[cnt_r] ? ACC_W'(num_r) : '0;
      end
      ST_MUL: begin
        alu_req.a = acc_r << 1;
        alu_req.b = mean_r[cnt_r[3:0]] ? mcand_r : '0;
      end
      ST_BIAS: begin
        alu_req.a = acc_r;
        if (acc_r[ACC_W-1]) begin
          alu_req.b = (ph_r == PH_P) ? BIAS_Q43 : BIAS_Q3;
        end
      end
      ST_ADDC: begin
        alu_req.a = ACC_W'($signed(acc_r) >>> 3);
        alu_req.b = (ph_r == PH_A1) ? ACC_W'(coef_i.square) : ACC_W'(coef_i.linear);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    mean_nxt  = mean_r;
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    ph_nxt    = ph_r;
    held_nxt  = held_r;
    upd_nxt   = upd_r;
    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          num_nxt   = {trimmed_i, 3'b000};
          acc_nxt   = '0;
          cnt_nxt   = BITCNT_W'(RECIP_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        acc_nxt = alu_sum;
        cnt_nxt = cnt_r - BITCNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        mean_nxt = quo;
        if (quo == '0) begin
          upd_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else if (quo == off8) begin
          upd_nxt   = 1'b1;
          held_nxt  = '0;
          state_nxt = ST_FIN;
        end else begin
          upd_nxt   = 1'b1;
          mcand_nxt = ACC_W'(coef_i.cubic);
          acc_nxt   = '0;
          cnt_nxt   = BITCNT_W'(MEAN_W - 1);
          ph_nxt    = PH_A1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt = alu_sum;
        cnt_nxt = cnt_r - BITCNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_BIAS;
        end
      end
      ST_BIAS: begin
        acc_nxt   = alu_sum;
        state_nxt = (ph_r == PH_P) ? ST_CODE : ST_ADDC;
      end
      ST_ADDC: begin
        mcand_nxt = sat_val;
        acc_nxt   = '0;
        cnt_nxt   = BITCNT_W'(MEAN_W - 1);
        ph_nxt    = ph_r + 2'd1;
        state_nxt = ST_MUL;
      end
      ST_CODE: begin
        held_nxt  = {below, mag};
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (take_i) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
      upd_r   <= 1'b0;
      ph_r    <= PH_A1;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      upd_r   <= upd_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    mean_r  <= mean_nxt;
    mcand_r <= mcand_nxt;
    acc_r   <= acc_nxt;
  end

  assign idle_o        = (state_r == ST_IDLE);
  assign res_o.valid   = (state_r == ST_FIN);
  assign res_o.code    = held_r;
  assign res_o.updated = upd_r;
  assign res_o.mean    = mean_r;

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start_i) |=> (state_r == ST_DIV))
    else $error("division did not start after a group completed");

  a_sign_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && upd_r && held_r[CODE_W-1]) |-> (mean_r < off8))
    else $error("negative code issued for a mean at or above the offset");

  a_no_upd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !upd_r) |-> (mean_r == '0))
    else $error("code left unrefreshed for a nonzero mean");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_BIAS) |-> (ph_r == PH_A1 || ph_r == PH_A2 ||
                                                  ph_r == PH_P))
    else $error("Horner phase out of range");

endmodule

### rtl/trimmed_mean_pressure_calibration_top.sv
`timescale 1ns / 1ps
// A sample that does not close a group only updates the running sum, maximum and minimum;
// ready stays high. The sample that closes a group starts the shared 64-bit adder
// sequence: a 24-step reciprocal multiply for the mean, a mean check, then three 15-step
// shift-add multiplies with their bias and coefficient steps, skipped when the mean is
// zero or equals the offset; out valid rises after the sequence. Input ready is low until
// the result leaves the core.
// Synchronous active-low reset clears counters and held code; coefficients get defaults.

module trimmed_mean_pressure_calibration_top
  import tmpc_pkg::*;
#(
  parameter int GROUP_SIZE = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tmpc_in_if.sink              in_if,
  tmpc_out_if.source           out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(GROUP_SIZE - 1);

  tmpc_coef_t          coef_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic [SUM_W-1:0]    trimmed;
  logic                accept, last, start, take, core_idle;
  tmpc_result_t        res;

  logic                out_valid_r;
  logic [CODE_W-1:0]   code_r;
  logic                upd_r;
  logic [MEAN_W-1:0]   mean_r;

  assign accept = in_if.valid && in_if.ready;
  assign last   = (cnt_r == LAST_IDX);
  assign start  = accept && last;

  always_comb begin
    if (cnt_r == '0) begin
      sum_nxt = SUM_W'(in_if.adc_sample);
      max_nxt = in_if.adc_sample;
      min_nxt = in_if.adc_sample;
    end else begin
      sum_nxt = sum_r + SUM_W'(in_if.adc_sample);
      max_nxt = (in_if.adc_sample > max_r) ? in_if.adc_sample : max_r;
      min_nxt = (in_if.adc_sample < min_r) ? in_if.adc_sample : min_r;
    end
  end

  assign trimmed = sum_nxt - SUM_W'(max_nxt) - SUM_W'(min_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.zero_offset <= ZERO_OFFSET_RST;
      coef_r.cubic       <= CUBIC_COEFF_RST;
      coef_r.square      <= SQUARE_COEFF_RST;
      coef_r.linear      <= LINEAR_COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ZERO_OFFSET:  coef_r.zero_offset <= cfg_wdata[SAMPLE_W-1:0];
        CFG_CUBIC_COEFF:  coef_r.cubic       <= cfg_wdata;
        CFG_SQUARE_COEFF: coef_r.square      <= cfg_wdata;
        CFG_LINEAR_COEFF: coef_r.linear      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      max_r <= '0;
      min_r <= '0;
    end else if (accept) begin
      cnt_r <= last ? '0 : cnt_r + CNT_W'(1);
      sum_r <= sum_nxt;
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  tmpc_core #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (start),
    .trimmed_i (trimmed),
    .coef_i    (coef_r),
    .take_i    (take),
    .idle_o    (core_idle),
    .res_o     (res)
  );

  assign in_if.ready = core_idle;

  // The result waits in the core until the output register is free for a transfer.
  assign take = res.valid && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_r <= res.code;
      upd_r  <= res.updated;
      mean_r <= res.mean;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.pressure_code = code_r;
  assign out_if.updated       = upd_r;
  assign out_if.mean_level    = mean_r;

endmodule
